@@ rtl/bma_pkg.sv @@
// shared constants and types for the boxcar moving average
// no dependencies

package bma_pkg;

    localparam int WINDOW_MAX    = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int CFG_BITS      = 9;
    localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
    localparam int COUNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS      = 24;
    localparam int FRAC_BITS     = 8;
    localparam int AVG_BITS      = 24;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LAUNCH,
        ST_DIVIDE
    } bma_state_t;

endpackage

@@ rtl/bma_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module bma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bma_div.sv @@
// signed by unsigned restoring divider, one quotient bit per cycle
// depends on bma_pkg

module bma_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [bma_pkg::DIVIDEND_BITS-1:0] dividend,
    input  logic [bma_pkg::COUNT_BITS-1:0]         divisor,
    output logic                                   done,
    output logic signed [bma_pkg::AVG_BITS-1:0]    quotient
);

    import bma_pkg::*;

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [COUNT_BITS-1:0]    div_reg;
    logic                     neg_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [COUNT_BITS:0]      trial;
    logic                     fits;
    logic [COUNT_BITS:0]      diff;
    logic [DIVIDEND_BITS-1:0] signed_quo;

    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (start) begin
            step_reg <= STEP_BITS'(DIVIDEND_BITS);
        end else if (step_reg != '0) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend[DIVIDEND_BITS-1] ? (~dividend + 1'b1) : dividend;
            neg_reg <= dividend[DIVIDEND_BITS-1];
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (step_reg != '0) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[AVG_BITS-1:0];
    assign done       = (step_reg == '0);

endmodule

@@ rtl/boxcar_moving_average.sv @@
// boxcar moving average top level: sample ring in ram, running sum, divider
// depends on bma_pkg, bma_ram, bma_div
//
// input channel s_*: one signed sample word per item, with s_series_start
// clearing the sum and count before the sample is taken.
// result channel m_*: one word per item, m_average is sum * 256 / count
// truncated toward zero, m_samples_used the count in the average.
// cfg_*: writes the window length (0 acts as 1, above 256 as 256) and
// clears sum and count; cfg_ready is always high, write only while idle.
// each word passes in order through the ring read on acceptance,
// the sum update and ring write, the divider launch, 32 divider
// steps (one quotient bit each) and the load of the output register,
// and s_ready stays low from acceptance until the output register loads.
// the divider loop sets the rate; the ring is a 256 x 16 ram.
// the result sits in an output register; a new word is taken while it
// waits, but a finished division holds until that register frees up.
// reset clears sum, count, ring position and sets the window to 1;
// ring contents are not cleared, entries are only used after a write.

module boxcar_moving_average (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bma_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                 s_series_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bma_pkg::AVG_BITS-1:0]  m_average,
    output logic [bma_pkg::COUNT_BITS-1:0]       m_samples_used,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bma_pkg::CFG_BITS-1:0]         cfg_data
);

    import bma_pkg::*;

    bma_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]         window_reg;
    logic [COUNT_BITS-1:0]         window_next;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [SLOT_BITS-1:0]          slot_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          full_reg;
    logic                          m_valid_reg;
    logic signed [AVG_BITS-1:0]    m_average_reg;
    logic [COUNT_BITS-1:0]         m_samples_used_reg;

    logic                          accept;
    logic                          cfg_write;
    logic                          out_load;
    logic [COUNT_BITS-1:0]         count_base;
    logic [SLOT_BITS-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [SUM_BITS-1:0]    old_ext;
    logic signed [SUM_BITS-1:0]    sum_update;
    logic                          div_done;
    logic signed [AVG_BITS-1:0]    div_quotient;
    logic                          ram_wr_en;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_DIVIDE) && div_done && (!m_valid_reg || m_ready);
    assign ram_wr_en = (state_reg == ST_UPDATE);

    assign count_base = s_series_start ? '0 : count_reg;
    assign rd_addr    = slot_reg - window_reg[SLOT_BITS-1:0];
    assign old_ext    = full_reg ? SUM_BITS'($signed(rd_data)) : '0;
    assign sum_update = sum_reg - old_ext + SUM_BITS'(sample_reg);

    always_comb begin
        window_next = cfg_data;
        if (cfg_data == '0) begin
            window_next = COUNT_BITS'(1);
        end else if (cfg_data > CFG_BITS'(WINDOW_MAX)) begin
            window_next = COUNT_BITS'(WINDOW_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= COUNT_BITS'(1);
            sum_reg    <= '0;
            count_reg  <= '0;
            slot_reg   <= '0;
        end else begin
            if (accept) begin
                full_reg   <= (count_base >= window_reg);
                count_reg  <= count_base;
                sample_reg <= s_sample;
                if (s_series_start) begin
                    sum_reg <= '0;
                end
            end
            if (state_reg == ST_UPDATE) begin
                sum_reg   <= sum_update;
                count_reg <= full_reg ? window_reg : count_reg + 1'b1;
                slot_reg  <= slot_reg + 1'b1;
            end
            if (cfg_write) begin
                window_reg <= window_next;
                sum_reg    <= '0;
                count_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_average_reg      <= div_quotient;
            m_samples_used_reg <= count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_average      = m_average_reg;
    assign m_samples_used = m_samples_used_reg;

    bma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LAUNCH),
        .dividend ({sum_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    a_count_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= window_reg)
        else $error("count exceeds window");

    a_window_range: assert property (@(posedge aclk) disable iff (!aresetn)
        window_reg != '0 && window_reg <= COUNT_BITS'(WINDOW_MAX))
        else $error("window out of range");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished division not loaded");

    a_used_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_samples_used_reg != '0)
        else $error("result with empty window");

    a_divider_idle_at_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LAUNCH |-> div_done)
        else $error("divider busy at launch");

endmodule

@@ verif/boxcar_moving_average_tb.sv @@
// self-checking testbench for boxcar_moving_average: directed table, then random phases
// depends on bma_pkg and the boxcar_moving_average rtl
`timescale 1ns / 100ps

module boxcar_moving_average_tb;
    import bma_pkg::*;

    typedef enum bit {
        ROW_SAMPLE,
        ROW_WINDOW
    } row_kind_t;

    typedef enum int {
        FILL_MIXED,
        FILL_TOP,
        FILL_BOTTOM
    } sample_fill_t;

    typedef struct packed {
        row_kind_t kind;
        int        value;
        bit        start;
        bit        typed;
        int        average;
        int        used;
    } script_row_t;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic [COUNT_BITS-1:0]      used;
    } mean_word_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          s_series_start;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [AVG_BITS-1:0]    m_average;
    logic [COUNT_BITS-1:0]         m_samples_used;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_BITS-1:0]           cfg_data;

    // filter state mirrored by the predictor
    logic signed [SAMPLE_BITS-1:0] hist_ring [WINDOW_MAX];
    longint                        running_total;
    int unsigned                   taken;
    logic [SLOT_BITS-1:0]          write_pos;
    logic [CFG_BITS-1:0]           window_reg;

    mean_word_t  pending_means [$];
    int unsigned mismatches = 0;
    bit          quiet_tail = 1'b0;

    script_row_t directed_rows [22] = '{
        '{ROW_SAMPLE, 32767, 1'b0, 1'b1, 8388352, 1},
        '{ROW_SAMPLE, -32768, 1'b0, 1'b1, -8388608, 1},
        '{ROW_SAMPLE, 0, 1'b1, 1'b1, 0, 1},
        '{ROW_SAMPLE, -1, 1'b0, 1'b1, -256, 1},
        // zero window acts as one
        '{ROW_WINDOW, 0, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 100, 1'b0, 1'b1, 25600, 1},
        '{ROW_SAMPLE, -3, 1'b0, 1'b1, -768, 1},
        '{ROW_WINDOW, 3, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 1, 1'b0, 1'b1, 256, 1},
        '{ROW_SAMPLE, 2, 1'b0, 1'b1, 384, 2},
        '{ROW_SAMPLE, 4, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 8, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, -7, 1'b1, 1'b1, -1792, 1},
        '{ROW_SAMPLE, 2, 1'b0, 1'b1, -640, 2},
        // negative mean truncates toward zero
        '{ROW_SAMPLE, 0, 1'b0, 1'b0, 0, 0},
        // oversized window acts as the maximum
        '{ROW_WINDOW, 511, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 32767, 1'b0, 1'b1, 8388352, 1},
        '{ROW_SAMPLE, -32768, 1'b0, 1'b1, -128, 2},
        '{ROW_SAMPLE, -32768, 1'b1, 1'b1, -8388608, 1},
        '{ROW_WINDOW, 256, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 32767, 1'b0, 1'b0, 0, 0},
        '{ROW_SAMPLE, 12345, 1'b1, 1'b0, 0, 0}
    };

    boxcar_moving_average u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_series_start (s_series_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_samples_used (m_samples_used),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic mean_word_t predict_mean(input logic signed [SAMPLE_BITS-1:0] smp,
                                                input logic start);
        int unsigned          w;
        logic [SLOT_BITS-1:0] old_slot;
        longint               scaled;
        mean_word_t           word;
        w = window_reg;
        if (w == 0) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        if (start) begin
            running_total = 0;
            taken = 0;
        end
        if (taken >= w) begin
            old_slot = write_pos - SLOT_BITS'(w);
            running_total -= longint'(hist_ring[old_slot]);
            taken = w;
        end else begin
            taken++;
        end
        hist_ring[write_pos] = smp;
        running_total += longint'(smp);
        write_pos++;
        scaled = running_total * 256;
        word.average = AVG_BITS'(scaled / longint'(taken));
        word.used = COUNT_BITS'(taken);
        return word;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_fill_t fill);
        logic signed [SAMPLE_BITS-1:0] smp;
        if (fill == FILL_TOP) begin
            smp = 16'sh7fff;
        end else if (fill == FILL_BOTTOM) begin
            smp = 16'sh8000;
        end else begin
            case ($urandom_range(0, 7))
                0: smp = 16'sh7fff;
                1: smp = 16'sh8000;
                2: smp = SAMPLE_BITS'(int'($urandom_range(0, 40)) - 20);
                default: smp = SAMPLE_BITS'($urandom);
            endcase
        end
        return smp;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic start,
                               input bit typed, input mean_word_t typed_word);
        mean_word_t word;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_series_start <= start;
        do @(posedge aclk); while (!s_ready);
        word = predict_mean(smp, start);
        if (typed) begin
            word = typed_word;
        end
        pending_means = {pending_means, word};
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] value);
        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_reg = value;
        running_total = 0;
        taken = 0;
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] window, input int unsigned words,
                             input int unsigned start_odds, input sample_fill_t fill);
        logic start;
        write_window(window);
        repeat (words) begin
            start = start_odds != 0 && $urandom_range(0, start_odds - 1) == 0;
            send_sample(pick_sample(fill), start, 1'b0, '0);
        end
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        mean_word_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                $error("result word with no expectation pending");
                mismatches++;
            end else begin
                exp_word = pending_means.pop_front();
                if (m_average !== exp_word.average) begin
                    $error("average: expected %0d, got %0d", exp_word.average, m_average);
                    mismatches++;
                end
                if (m_samples_used !== exp_word.used) begin
                    $error("samples_used: expected %0d, got %0d", exp_word.used,
                           m_samples_used);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        script_row_t row;
        mean_word_t  typed_word;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_sample <= '0;
        s_series_start <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        window_reg = CFG_BITS'(1);
        running_total = 0;
        taken = 0;
        write_pos = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WINDOW) begin
                write_window(CFG_BITS'(row.value));
            end else begin
                typed_word.average = AVG_BITS'(row.average);
                typed_word.used = COUNT_BITS'(row.used);
                send_sample(SAMPLE_BITS'(row.value), row.start, row.typed, typed_word);
            end
        end

        run_phase(CFG_BITS'(2), 60, 20, FILL_MIXED);
        run_phase(CFG_BITS'(511), 264, 0, FILL_TOP);
        run_phase(CFG_BITS'(100), 150, 0, FILL_MIXED);
        run_phase(CFG_BITS'(7), 20, 0, FILL_BOTTOM);
        run_phase(CFG_BITS'(5), 80, 15, FILL_MIXED);
        repeat (3) run_phase(CFG_BITS'($urandom_range(1, 40)), 50, 25, FILL_MIXED);
        run_phase(CFG_BITS'($urandom), 40, 10, FILL_MIXED);
        run_phase(CFG_BITS'(1), 40, 4, FILL_MIXED);
        quiet_tail = 1'b1;
        run_phase(CFG_BITS'($urandom_range(2, 16)), 80, 30, FILL_MIXED);

        s_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bma_pkg.sv
rtl/bma_ram.sv
rtl/bma_div.sv
rtl/boxcar_moving_average.sv
verif/boxcar_moving_average_tb.sv
